@@ design/literal_repeat_run_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// literal_repeat_run_decoder_macros.svh
// Assertion macros for the literal/repeat run decoder; they compile to
// nothing when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef LITERAL_REPEAT_RUN_DECODER_MACROS_SVH
`define LITERAL_REPEAT_RUN_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define LRRD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// next-cycle implication
`define LRRD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define LRRD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LRRD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ design/lrrd_pkg.sv @@
// ----------------------------------------------------------------------------
// lrrd_pkg
// Types and codes shared by the literal/repeat run decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lrrd_pkg;

	// input commands
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_BYTE  = 1'b1;

	// result status codes
	localparam logic [1:0] ST_RUN     = 2'd0;
	localparam logic [1:0] ST_DONE    = 2'd1;
	localparam logic [1:0] ST_MIDRUN  = 2'd2;
	localparam logic [1:0] ST_IGNORED = 2'd3;

	localparam logic [15:0] TRACK_LENGTH_RESET = 16'd9216;

	typedef struct packed {
		logic        cmd;
		logic [15:0] block_length;
		logic [7:0]  data_byte;
	} item_t;

	typedef struct packed {
		logic [15:0] write_offset;
		logic [7:0]  fill_value;
		logic [7:0]  fill_count;
		logic [1:0]  status;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

@@ design/lrrd_item_if.sv @@
// ----------------------------------------------------------------------------
// lrrd_item_if
// Valid/ready channel carrying one compressed input item.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrrd_item_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [15:0] block_length;
	logic [7:0]  data_byte;

	modport source (output valid, output cmd, output block_length, output data_byte,
		input ready);
	modport sink (input valid, input cmd, input block_length, input data_byte,
		output ready);
endinterface

`default_nettype wire

@@ design/lrrd_result_if.sv @@
// ----------------------------------------------------------------------------
// lrrd_result_if
// Valid/ready channel carrying one track write command.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrrd_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] write_offset;
	logic [7:0]  fill_value;
	logic [7:0]  fill_count;
	logic [1:0]  status;
	logic        last;

	modport source (output valid, output write_offset, output fill_value,
		output fill_count, output status, output last, input ready);
	modport sink (input valid, input write_offset, input fill_value,
		input fill_count, input status, input last, output ready);
endinterface

`default_nettype wire

@@ design/literal_repeat_run_decoder.sv @@
// ----------------------------------------------------------------------------
// literal_repeat_run_decoder
// Decodes a literal/repeat run-length stream one byte per item into track
// write commands (offset, value, count) with block status.
//
//   channel   dir   handshake         payload
//   item      in    valid / ready     cmd, block_length, data_byte
//   result    out   valid / ready     write_offset, fill_value, fill_count,
//                                     status, last
//   cfg       in    cfg_we            cfg_wdata (track_length)
//
// One item per cycle sustained while the result side takes each result; a
// result is offered once its item has passed the input register, then the
// result register.
// The run state updates in one pass of compare/subtract logic per item.
// Reset clears the run state to idle and loads track_length with 9216.
// A stalled result holds the result register and, through it, the input.
// ----------------------------------------------------------------------------
`default_nettype none

module literal_repeat_run_decoder #(
	parameter int OFFSET_BITS = 16
) (
	input  wire            clk,
	input  wire            arst_n,
	lrrd_item_if.sink      item,
	lrrd_result_if.source  result,
	input  wire            cfg_we,
	input  wire  [15:0]    cfg_wdata
);
	import lrrd_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	result_t res;
	logic    space;
	logic    advance;

	// move the held item on when the result register has room
	assign advance = valid_s1 && space;

	lrrd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	lrrd_step #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.advance   (advance),
		.res       (res)
	);

	lrrd_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (valid_s1),
		.res_in   (res),
		.space    (space),
		.result   (result)
	);

endmodule

`default_nettype wire

@@ design/lrrd_in_reg.sv @@
// ----------------------------------------------------------------------------
// lrrd_in_reg
// Input stage register: captures one item per transfer and holds it until
// the decode stage moves it on.
// ----------------------------------------------------------------------------
`default_nettype none

module lrrd_in_reg (
	input  wire                 clk,
	input  wire                 arst_n,
	lrrd_item_if.sink           item,
	input  wire                 advance,
	output logic                valid_s1,
	output lrrd_pkg::item_t     item_s1
);
	import lrrd_pkg::*;

	logic take;

	// accept when empty or when the held item leaves this cycle
	assign item.ready = !valid_s1 || advance;
	assign take       = item.valid && item.ready;

	// hold the stage valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	// capture the payload on transfer
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.cmd          <= item.cmd;
			item_s1.block_length <= item.block_length;
			item_s1.data_byte    <= item.data_byte;
		end
	end

endmodule

`default_nettype wire

@@ design/lrrd_step.sv @@
// ----------------------------------------------------------------------------
// lrrd_step
// Decode state and next-state logic: turns the held item into one write
// command and advances the run state when the item moves on.
// ----------------------------------------------------------------------------
`default_nettype none

`include "literal_repeat_run_decoder_macros.svh"

module lrrd_step #(
	parameter int OFFSET_BITS = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire  [15:0]         cfg_wdata,
	input  wire                 valid_s1,
	input  lrrd_pkg::item_t     item_s1,
	input  wire                 advance,
	output lrrd_pkg::result_t   res
);
	import lrrd_pkg::*;

	localparam int W = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_LEN   = 3'd1;
	localparam logic [2:0] PH_LIT   = 3'd2;
	localparam logic [2:0] PH_COUNT = 3'd3;
	localparam logic [2:0] PH_REP   = 3'd4;

	logic [15:0]            tl_q;
	logic [2:0]             phase_q,  phase_d;
	logic [15:0]            bll_q,    bll_d;
	logic [7:0]             lit_q,    lit_d;
	logic [7:0]             rep_q,    rep_d;
	logic [OFFSET_BITS-1:0] off_q,    off_d;

	logic [W-1:0]  off_ext;
	logic [W-1:0]  tl_ext;
	logic [W-1:0]  room;
	logic [15:0]   bll_dec;
	logic [7:0]    lit_dec;
	logic [7:0]    len_blk;
	logic [7:0]    len_cut;
	logic [7:0]    rep_cut;

	// track length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q <= TRACK_LENGTH_RESET;
		end else if (cfg_we) begin
			tl_q <= cfg_wdata;
		end
	end

	// room left in the track, zero once the offset has reached the end
	assign off_ext = W'(off_q);
	assign tl_ext  = W'(tl_q);
	assign room    = (tl_ext > off_ext) ? (tl_ext - off_ext) : '0;
	assign bll_dec = bll_q - 16'd1;
	assign lit_dec = lit_q - 8'd1;

	// literal length cut to block bytes left, then to room
	assign len_blk = ({8'd0, item_s1.data_byte} > bll_dec) ? bll_dec[7:0] : item_s1.data_byte;
	assign len_cut = (W'(len_blk) > room) ? room[7:0] : len_blk;
	// repeat count cut to room
	assign rep_cut = (W'(rep_q) > room) ? room[7:0] : rep_q;

	// next state and result
	always_comb begin
		phase_d = phase_q;
		bll_d   = bll_q;
		lit_d   = lit_q;
		rep_d   = rep_q;
		off_d   = off_q;
		res.write_offset = off_ext[15:0];
		res.fill_value   = 8'd0;
		res.fill_count   = 8'd0;
		res.status       = ST_RUN;
		res.last         = 1'b0;
		if (item_s1.cmd == CMD_START) begin
			off_d = '0;
			lit_d = 8'd0;
			rep_d = 8'd0;
			bll_d = item_s1.block_length;
			res.write_offset = 16'd0;
			if (item_s1.block_length == 16'd0) begin
				phase_d    = PH_IDLE;
				res.status = ST_DONE;
				res.last   = 1'b1;
			end else begin
				phase_d = PH_LEN;
			end
		end else begin
			case (phase_q)
				PH_LEN: begin
					bll_d = bll_dec;
					if (bll_dec == 16'd0) begin
						phase_d    = PH_IDLE;
						res.status = ST_MIDRUN;
						res.last   = 1'b1;
					end else begin
						lit_d   = len_cut;
						phase_d = (len_cut == 8'd0) ? PH_COUNT : PH_LIT;
					end
				end
				PH_LIT: begin
					off_d = off_q + OFFSET_BITS'(1);
					bll_d = bll_dec;
					lit_d = lit_dec;
					res.fill_value = item_s1.data_byte;
					res.fill_count = 8'd1;
					if (bll_dec == 16'd0) begin
						phase_d    = PH_IDLE;
						res.status = ST_DONE;
						res.last   = 1'b1;
					end else if (lit_dec == 8'd0) begin
						phase_d = PH_COUNT;
					end
				end
				PH_COUNT: begin
					bll_d = bll_dec;
					if (bll_dec == 16'd0) begin
						phase_d    = PH_IDLE;
						res.status = ST_MIDRUN;
						res.last   = 1'b1;
					end else begin
						rep_d   = item_s1.data_byte;
						phase_d = PH_REP;
					end
				end
				PH_REP: begin
					bll_d = bll_dec;
					off_d = off_q + OFFSET_BITS'(rep_cut);
					rep_d = 8'd0;
					res.fill_value = (rep_cut != 8'd0) ? item_s1.data_byte : 8'd0;
					res.fill_count = rep_cut;
					if (bll_dec == 16'd0) begin
						phase_d    = PH_IDLE;
						res.status = ST_DONE;
						res.last   = 1'b1;
					end else begin
						phase_d = PH_LEN;
					end
				end
				default: begin
					phase_d    = PH_IDLE;
					res.status = ST_IGNORED;
				end
			endcase
		end
	end

	// advance the run state when the item leaves the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bll_q   <= 16'd0;
			lit_q   <= 8'd0;
			rep_q   <= 8'd0;
			off_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			bll_q   <= bll_d;
			lit_q   <= lit_d;
			rep_q   <= rep_d;
			off_q   <= off_d;
		end
	end

	`LRRD_ASSERT_IMP(a_write_only_running, clk, arst_n, valid_s1 && (res.fill_count != 8'd0), (res.status == ST_RUN) || (res.status == ST_DONE))
	`LRRD_ASSERT_IMP(a_last_ends_block, clk, arst_n, valid_s1 && res.last, (res.status == ST_DONE) || (res.status == ST_MIDRUN))
	`LRRD_ASSERT_NXT(a_start_clears_offset, clk, arst_n, advance && (item_s1.cmd == CMD_START), off_q == '0)
	`LRRD_ASSERT_NXT(a_block_end_idles, clk, arst_n, advance && res.last, phase_q == PH_IDLE)

endmodule

`default_nettype wire

@@ design/lrrd_out_reg.sv @@
// ----------------------------------------------------------------------------
// lrrd_out_reg
// Result register: holds one write command until the consumer takes it,
// and lets the next one in during the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lrrd_out_reg (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 valid_in,
	input  lrrd_pkg::result_t   res_in,
	output logic                space,
	lrrd_result_if.source       result
);
	import lrrd_pkg::*;

	logic    valid_q;
	result_t res_q;

	// free when empty or when the held result transfers now
	assign space = !valid_q || result.ready;

	// hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= valid_in;
		end
	end

	// load the payload
	always_ff @(posedge clk) begin
		if (space && valid_in) begin
			res_q <= res_in;
		end
	end

	assign result.valid        = valid_q;
	assign result.write_offset = res_q.write_offset;
	assign result.fill_value   = res_q.fill_value;
	assign result.fill_count   = res_q.fill_count;
	assign result.status       = res_q.status;
	assign result.last         = res_q.last;

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the literal/repeat run decoder. Directed blocks hit
// empty blocks, abandoned blocks, idle bytes, mid-run block ends and cuts to
// block and track room. Random well-formed blocks with some noise follow,
// under several track lengths. A scoreboard decodes every transfer into the
// expected write command and checks each result against it, field by field.
// ----------------------------------------------------------------------------
module tb;
	import lrrd_pkg::*;

	typedef enum logic [2:0] {DEC_IDLE, DEC_LEN, DEC_LIT, DEC_COUNT, DEC_REP} dec_phase_t;

	// Track write scoreboard: decodes items and holds the writes still owed
	class track_write_scoreboard;
		logic [15:0] track_length;
		dec_phase_t  phase;
		logic [15:0] block_left;
		logic [7:0]  literal_left;
		logic [7:0]  repeat_count;
		logic [15:0] offset;
		result_t     pending_writes[$];
		int          errors;

		function new();
			track_length = TRACK_LENGTH_RESET;
			phase = DEC_IDLE;
			block_left = '0;
			literal_left = '0;
			repeat_count = '0;
			offset = '0;
			errors = 0;
		endfunction

		function void set_track_length(logic [15:0] v);
			track_length = v;
		endfunction

		function int unsigned room();
			return (track_length > offset) ? 32'(track_length) - 32'(offset) : 0;
		endfunction

		// Advance the decoder state by one transfer and queue its write command
		function void decode_item(item_t it);
			result_t     w;
			int unsigned n;
			w = '0;
			w.write_offset = offset;
			if (it.cmd == CMD_START) begin
				offset = '0;
				literal_left = '0;
				repeat_count = '0;
				block_left = it.block_length;
				w.write_offset = '0;
				if (it.block_length == 16'd0) begin
					phase = DEC_IDLE;
					w.status = ST_DONE;
					w.last = 1'b1;
				end else begin
					phase = DEC_LEN;
					w.status = ST_RUN;
				end
			end else begin
				case (phase)
					DEC_LEN: begin
						block_left = block_left - 16'd1;
						if (block_left == 16'd0) begin
							phase = DEC_IDLE;
							w.status = ST_MIDRUN;
							w.last = 1'b1;
						end else begin
							// cut the literal to the block, then to the track
							n = 32'(it.data_byte);
							if (n > 32'(block_left))
								n = 32'(block_left);
							if (n > room())
								n = room();
							literal_left = 8'(n);
							phase = (n == 0) ? DEC_COUNT : DEC_LIT;
						end
					end
					DEC_LIT: begin
						w.fill_value = it.data_byte;
						w.fill_count = 8'd1;
						offset = offset + 16'd1;
						block_left = block_left - 16'd1;
						literal_left = literal_left - 8'd1;
						if (block_left == 16'd0) begin
							phase = DEC_IDLE;
							w.status = ST_DONE;
							w.last = 1'b1;
						end else if (literal_left == 8'd0) begin
							phase = DEC_COUNT;
						end
					end
					DEC_COUNT: begin
						block_left = block_left - 16'd1;
						if (block_left == 16'd0) begin
							phase = DEC_IDLE;
							w.status = ST_MIDRUN;
							w.last = 1'b1;
						end else begin
							repeat_count = it.data_byte;
							phase = DEC_REP;
						end
					end
					DEC_REP: begin
						block_left = block_left - 16'd1;
						n = 32'(repeat_count);
						if (n > room())
							n = room();
						w.fill_count = 8'(n);
						w.fill_value = (n != 0) ? it.data_byte : 8'd0;
						offset = offset + 16'(n);
						repeat_count = '0;
						if (block_left == 16'd0) begin
							phase = DEC_IDLE;
							w.status = ST_DONE;
							w.last = 1'b1;
						end else begin
							phase = DEC_LEN;
						end
					end
					default: begin
						phase = DEC_IDLE;
						w.status = ST_IGNORED;
					end
				endcase
			end
			pending_writes.push_back(w);
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s expected %0d got %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		// Match one result transfer against the oldest owed write
		function void check_write(result_t got);
			result_t want;
			if (pending_writes.size() == 0) begin
				$display("%0t: unexpected result, expected none got %h", $time, got);
				errors++;
				return;
			end
			want = pending_writes.pop_front();
			compare_field("write_offset", 32'(want.write_offset), 32'(got.write_offset));
			compare_field("fill_value", 32'(want.fill_value), 32'(got.fill_value));
			compare_field("fill_count", 32'(want.fill_count), 32'(got.fill_count));
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("last", 32'(want.last), 32'(got.last));
		endfunction

		function void check_drained();
			if (pending_writes.size() != 0) begin
				$display("%0t: %0d results expected, got none", $time, pending_writes.size());
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	lrrd_item_if   item_ch ();
	lrrd_result_if result_ch ();

	track_write_scoreboard sb = new();

	int burst_left = 0;
	int items_sent = 0;
	int stall_pct = 0;
	int stall_mode_left = 0;

	literal_repeat_run_decoder #(
		.OFFSET_BITS(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the result side, switching the stall rate at random intervals
	always @(posedge clk) begin
		if (stall_mode_left == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 85;
			endcase
			stall_mode_left = $urandom_range(50, 300);
		end else begin
			stall_mode_left--;
		end
		result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_write({result_ch.write_offset, result_ch.fill_value,
				result_ch.fill_count, result_ch.status, result_ch.last});
	end

	// Send one item, opening a new burst after a random gap when the last one ran out
	task send_item(input logic cmd, input logic [15:0] blen, input logic [7:0] b);
		item_t it;
		it = {cmd, blen, b};
		if (burst_left == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200) :
				$urandom_range(1, 16);
		end
		item_ch.valid <= 1'b1;
		item_ch.cmd <= cmd;
		item_ch.block_length <= blen;
		item_ch.data_byte <= b;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		sb.decode_item(it);
		burst_left--;
		items_sent++;
	endtask

	// Hold the sender until every owed result has come back
	task drain();
		item_ch.valid <= 1'b0;
		burst_left = 0;
		while (sb.pending_writes.size() != 0)
			@(posedge clk);
	endtask

	task write_track_length(input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_track_length(v);
	endtask

	// One block of mostly well-formed runs with random content; some noise
	task send_block();
		int unsigned kind;
		int unsigned blen;
		int unsigned nbytes;
		int unsigned lit_n;
		dec_phase_t  g;
		logic [7:0]  b;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			blen = $urandom_range(0, 65535);
			nbytes = $urandom_range(0, 4);
		end else begin
			blen = (kind < 78) ? $urandom_range(1, 24) : $urandom_range(25, 120);
			nbytes = blen;
			// abandon some blocks early
			if ($urandom_range(0, 9) == 0)
				nbytes = $urandom_range(0, blen - 1);
		end
		send_item(CMD_START, 16'(blen), 8'($urandom));
		g = DEC_LEN;
		lit_n = 0;
		repeat (nbytes) begin
			case (g)
				DEC_LEN: begin
					case ($urandom_range(0, 19))
						0, 1, 2: b = 8'($urandom_range(41, 255));
						3, 4, 5, 6, 7: b = 8'($urandom_range(7, 40));
						default: b = 8'($urandom_range(0, 6));
					endcase
					lit_n = 32'(b);
					g = (b == 8'd0) ? DEC_COUNT : DEC_LIT;
				end
				DEC_LIT: begin
					b = 8'($urandom);
					lit_n--;
					if (lit_n == 0)
						g = DEC_COUNT;
				end
				DEC_COUNT: begin
					b = $urandom_range(0, 1) ? 8'($urandom_range(0, 8)) : 8'($urandom);
					g = DEC_REP;
				end
				default: begin
					b = 8'($urandom);
					g = DEC_LEN;
				end
			endcase
			send_item(CMD_BYTE, 16'($urandom), b);
		end
		// stray bytes after the block
		if ($urandom_range(0, 19) == 0)
			repeat ($urandom_range(1, 3))
				send_item(CMD_BYTE, 16'($urandom), 8'($urandom));
	endtask

	int unsigned track_settings[7] = '{1, 65535, 16, 9216, 0, 37, 0};
	int unsigned phase_start;
	logic [15:0] tl;

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.cmd = CMD_START;
		item_ch.block_length = '0;
		item_ch.data_byte = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte while idle, empty block
		send_item(CMD_BYTE, 16'h0000, 8'hFF);
		send_item(CMD_START, 16'h0000, 8'h00);

		// long block, then shrink the track under it mid-literal
		send_item(CMD_START, 16'hFFFF, 8'h00);
		send_item(CMD_BYTE, 16'h0000, 8'd5);
		send_item(CMD_BYTE, 16'h0000, 8'hAA);
		send_item(CMD_BYTE, 16'h0000, 8'h55);
		drain();
		write_track_length(16'd3);
		send_item(CMD_BYTE, 16'h0000, 8'h0F);
		send_item(CMD_BYTE, 16'h0000, 8'hF0);
		send_item(CMD_BYTE, 16'h0000, 8'h81);
		send_item(CMD_BYTE, 16'h0000, 8'hFF);
		send_item(CMD_BYTE, 16'h0000, 8'h00);
		send_item(CMD_BYTE, 16'h0000, 8'd1);

		// start while busy, then block ends right after a length byte
		send_item(CMD_START, 16'd1, 8'h00);
		send_item(CMD_BYTE, 16'h0000, 8'd7);

		// empty literal, repeat cut to the room left
		send_item(CMD_START, 16'd3, 8'h00);
		send_item(CMD_BYTE, 16'h0000, 8'd0);
		send_item(CMD_BYTE, 16'h0000, 8'd5);
		send_item(CMD_BYTE, 16'h0000, 8'h3C);

		// block ends right after a count byte
		send_item(CMD_START, 16'd2, 8'h00);
		send_item(CMD_BYTE, 16'h0000, 8'd0);
		send_item(CMD_BYTE, 16'h0000, 8'd9);

		// literal cut to the block, block ends on a literal byte
		send_item(CMD_START, 16'd4, 8'h00);
		send_item(CMD_BYTE, 16'h0000, 8'd200);
		send_item(CMD_BYTE, 16'h0000, 8'h11);
		send_item(CMD_BYTE, 16'h0000, 8'h22);
		send_item(CMD_BYTE, 16'h0000, 8'h33);

		// random blocks under a range of track lengths
		foreach (track_settings[p]) begin
			drain();
			tl = (track_settings[p] != 0) ? 16'(track_settings[p]) :
				(p == 4) ? 16'($urandom_range(1, 300)) : 16'($urandom_range(1, 65535));
			write_track_length(tl);
			phase_start = items_sent;
			while (items_sent - phase_start < 200)
				send_block();
		end

		drain();
		repeat (10) @(posedge clk);
		sb.check_drained();
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Stop a hung run
	initial begin
		#5000000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
